FILE: rtl/core/lfpc_pkg.sv
package lfpc_pkg;

    localparam int IDX_W = 14;

    typedef logic [IDX_W-1:0] t_idx;

    // action codes of an input item
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_HIT  = 1'b1;

endpackage

FILE: rtl/core/lfpc_ram.sv
module lfpc_ram #(
    parameter int WIDTH  = 14,
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lca_fold_parent_climb_unit.sv
// Lowest common ancestor of a list of hit nodes, found by climbing a parent table held
// in one single-port-read memory. A load item writes one parent entry; the first hit of
// a list records its node. Each later hit walks its pair up the table while they differ;
// every step is one read of the parent memory, whose data comes back in the next cycle.
// A walk ends when both indices meet, or when a parent link does not point to a smaller
// index or an index lies beyond the table, which sets the fault flag. The hit marked last
// then moves the result into the output register through an emit state, waiting there
// while an earlier result is still not taken. The result register lets the next item be
// accepted while a finished result waits. No clearing pass is needed after reset.
module lca_fold_parent_climb_unit #(
    parameter int NODES = 16384
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_action,
    input  logic [lfpc_pkg::IDX_W-1:0] i_node,
    input  logic [lfpc_pkg::IDX_W-1:0] i_parent,
    input  logic                      i_last,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [lfpc_pkg::IDX_W-1:0] o_ancestor,
    output logic                      o_fault
);

    localparam int ADDR_W = (NODES > 1) ? $clog2(NODES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_EMIT
    } t_state;

    t_state          r_state;
    logic            r_open;
    logic            r_fault_seen;
    logic            r_last;
    lfpc_pkg::t_idx  r_ra;
    lfpc_pkg::t_idx  r_a;
    lfpc_pkg::t_idx  r_b;
    logic            r_out_valid;
    lfpc_pkg::t_idx  r_out_anc;
    logic            r_out_fault;

    logic            w_accept;
    logic [31:0]     w_node_ext;
    logic            w_node_in;
    logic            w_we;
    lfpc_pkg::t_idx  w_rdata;
    lfpc_pkg::t_idx  w_read_idx;
    logic            w_bad_link;
    lfpc_pkg::t_idx  n_a;
    lfpc_pkg::t_idx  n_b;
    lfpc_pkg::t_idx  w_pa;
    lfpc_pkg::t_idx  w_pb;
    logic            w_eq;
    lfpc_pkg::t_idx  w_big;
    logic [31:0]     w_big_ext;
    logic            w_big_in;
    logic            w_out_free;
    logic            w_emit;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_node_ext = 32'(i_node);
    assign w_node_in  = w_node_ext < 32'(NODES);
    assign w_we       = w_accept && (i_action == lfpc_pkg::ACT_LOAD) && w_node_in;

    // one walk step: the larger index was read last cycle and is replaced by its parent
    always_comb begin
        w_read_idx = (r_a > r_b) ? r_a : r_b;
        w_bad_link = w_rdata >= w_read_idx;
        n_a = (r_a > r_b) ? w_rdata : r_a;
        n_b = (r_a > r_b) ? r_b : w_rdata;
    end

    // pair to resolve this cycle: fresh fold in idle, stepped pair in a walk
    assign w_pa      = (r_state == S_WALK) ? n_a : r_ra;
    assign w_pb      = (r_state == S_WALK) ? n_b : i_node;
    assign w_eq      = w_pa == w_pb;
    assign w_big     = (w_pa > w_pb) ? w_pa : w_pb;
    assign w_big_ext = 32'(w_big);
    assign w_big_in  = w_big_ext < 32'(NODES);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_emit     = (r_state == S_EMIT) && w_out_free;

    lfpc_ram #(
        .WIDTH  (lfpc_pkg::IDX_W),
        .DEPTH  (NODES),
        .ADDR_W (ADDR_W)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_node_ext[ADDR_W-1:0]),
        .i_wdata (i_parent),
        .i_raddr (w_big_ext[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_open       <= 1'b0;
            r_fault_seen <= 1'b0;
            r_ra         <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && !w_emit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_action == lfpc_pkg::ACT_HIT)) begin
                        r_last <= i_last;
                        if (!r_open) begin
                            r_ra         <= i_node;
                            r_fault_seen <= 1'b0;
                            r_open       <= 1'b1;
                            r_state      <= i_last ? S_EMIT : S_IDLE;
                        end else if (w_eq) begin
                            r_state <= i_last ? S_EMIT : S_IDLE;
                        end else if (!w_big_in) begin
                            // index beyond the table counts as self-parented
                            r_fault_seen <= 1'b1;
                            r_state      <= i_last ? S_EMIT : S_IDLE;
                        end else begin
                            r_a     <= w_pa;
                            r_b     <= w_pb;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_WALK: begin
                    if (w_bad_link || (!w_eq && !w_big_in)) begin
                        r_fault_seen <= 1'b1;
                        r_state      <= r_last ? S_EMIT : S_IDLE;
                    end else if (w_eq) begin
                        r_ra    <= n_a;
                        r_state <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_a <= n_a;
                        r_b <= n_b;
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_anc    <= r_ra;
                        r_out_fault  <= r_fault_seen;
                        r_open       <= 1'b0;
                        r_fault_seen <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ancestor  = r_out_anc;
    assign o_fault     = r_out_fault;

endmodule

FILE: rtl/core/lfpc_chk.sv
module lfpc_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      i_action,
    input logic                      i_last,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [lfpc_pkg::IDX_W-1:0] o_ancestor,
    input logic                      o_fault
);

    logic       w_in_acc;
    logic       w_out_acc;
    logic       w_last_hit;
    logic [1:0] r_owed;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_out_acc  = o_out_valid && i_out_ready;
    assign w_last_hit = w_in_acc && (i_action == lfpc_pkg::ACT_HIT) && i_last;

    // results owed: last hits accepted minus results taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owed <= '0;
        end else begin
            r_owed <= r_owed + 2'(w_last_hit) - 2'(w_out_acc);
        end
    end

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_owed != 2'd0)
        else $error("result shown with no last hit owed");

    a_two_owed_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_owed == 2'd2 |-> !o_in_ready)
        else $error("input taken while two results are owed");

    a_load_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_action == lfpc_pkg::ACT_LOAD) |=> o_in_ready)
        else $error("load item did not finish in one cycle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_ancestor) && $stable(o_fault)))
        else $error("stalled result changed or dropped");

endmodule

bind lca_fold_parent_climb_unit lfpc_chk u_lfpc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_action    (i_action),
    .i_last      (i_last),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_ancestor  (o_ancestor),
    .o_fault     (o_fault)
);
